@@ design/bfha_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package bfha_pkg;

  localparam int unsigned ADDR_W = 32;

  localparam logic [ADDR_W-1:0] HDR_BYTES    = 32'd4;
  localparam logic [ADDR_W-1:0] FIRST_OFFSET = 32'd1048576;
  localparam logic [ADDR_W-1:0] ADDR_MAX     = 32'hFFFF_FFFF;

  localparam logic [1:0] MODE_ADD   = 2'd0;
  localparam logic [1:0] MODE_ALLOC = 2'd1;
  localparam logic [1:0] MODE_FREE  = 2'd2;

  localparam logic [1:0] STS_OK    = 2'd0;
  localparam logic [1:0] STS_ZERO  = 2'd1;
  localparam logic [1:0] STS_NOMEM = 2'd2;
  localparam logic [1:0] STS_FULL  = 2'd3;

  localparam logic [7:0] TYPE_RAM = 8'd1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_COMMIT
  } state_e;

  typedef struct packed {
    logic [ADDR_W-1:0] base_addr;
    logic [ADDR_W-1:0] end_addr;
  } hole_t;

  typedef struct packed {
    logic free_found;
    logic best_found;
    logic best_exact;
    logic lo_found;
    logic hi_found;
  } scan_flags_t;

  function automatic logic [ADDR_W-1:0] sat33(input logic [ADDR_W:0] v);
    sat33 = v[ADDR_W] ? ADDR_MAX : v[ADDR_W-1:0];
  endfunction

endpackage

`default_nettype wire

@@ design/best_fit_hole_allocator.sv @@
// channel   direction  handshake                  payload
// in        input      in_valid_i / in_ready_o    mode_i, address_i, amount_i, region_type_i
// out       output     out_valid_o / out_ready_i  result_address_o, status_o
// cfg       input      cfg_we_i                   cfg_wdata_i (kernel_end)
//
// the hole memory is read one entry per cycle while scanning, then the commit state
// writes back the hole and registers the result.
// a result waiting on out_ready_i holds the commit cycle, so the next item waits too.
// reset clears the valid bits and the first-region flag at once; no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module best_fit_hole_allocator #(
  parameter int unsigned NUM_HOLES = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [31:0] cfg_wdata_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [1:0]  mode_i,
  input  wire logic [31:0] address_i,
  input  wire logic [31:0] amount_i,
  input  wire logic [7:0]  region_type_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [31:0]      result_address_o,
  output logic [1:0]       status_o
);

  localparam int unsigned IW = $clog2(NUM_HOLES);
  localparam int unsigned CW = IW + 1;
  localparam int unsigned AW = bfha_pkg::ADDR_W;

  bfha_pkg::state_e state_q, state_d;

  logic [CW-1:0] cnt_q, cnt_d;
  logic          rd_pend_q;
  logic [IW-1:0] rd_idx_q;

  logic [1:0]    mode_q;
  logic [AW-1:0] addr_q, amount_q, hdr_q, fbase_q, kernel_end_q;
  logic [7:0]    type_q;
  logic [AW:0]   need_q, rend_q, blk_end_q, fstart_q;

  logic [NUM_HOLES-1:0] valid_q, valid_d;
  logic                 first_taken_q, first_taken_d;

  logic          res_valid_q;
  logic [AW-1:0] res_addr_q, res_addr_d;
  logic [1:0]    res_sts_q, res_sts_d;

  logic in_fire, mem_re, scan_done, commit_fire;

  bfha_pkg::hole_t       rd_hole, wr_hole;
  bfha_pkg::scan_flags_t flags;
  bfha_pkg::hole_t       best_hole, lo_hole, hi_hole;
  logic [IW-1:0]         free_idx, best_idx, lo_idx, hi_idx;

  logic          wr_en, set_en, clr_en;
  logic [IW-1:0] wr_idx, set_idx, clr_idx;
  logic [AW-1:0] add_start, add_end, new_start, blk_sat_end;

  assign in_fire   = in_valid_i && in_ready_o;
  assign scan_done = (cnt_q == CW'(NUM_HOLES));

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      bfha_pkg::ST_IDLE: begin
        if (in_fire) begin
          state_d = bfha_pkg::ST_SCAN;
        end
      end
      bfha_pkg::ST_SCAN: begin
        if (scan_done) begin
          state_d = bfha_pkg::ST_COMMIT;
        end
      end
      bfha_pkg::ST_COMMIT: begin
        if (commit_fire) begin
          state_d = bfha_pkg::ST_IDLE;
        end
      end
      default: state_d = bfha_pkg::ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_ready_o  = 1'b0;
    mem_re      = 1'b0;
    commit_fire = 1'b0;
    case (state_q)
      bfha_pkg::ST_IDLE:   in_ready_o  = 1'b1;
      bfha_pkg::ST_SCAN:   mem_re      = (cnt_q < CW'(NUM_HOLES));
      bfha_pkg::ST_COMMIT: commit_fire = !res_valid_q || out_ready_i;
      default: ;
    endcase
  end

  always_comb begin
    cnt_d = cnt_q;
    if (in_fire) begin
      cnt_d = '0;
    end else if (state_q == bfha_pkg::ST_SCAN) begin
      cnt_d = cnt_q + CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= bfha_pkg::ST_IDLE;
      cnt_q         <= '0;
      rd_pend_q     <= 1'b0;
      valid_q       <= '0;
      first_taken_q <= 1'b0;
      kernel_end_q  <= '0;
      res_valid_q   <= 1'b0;
    end else begin
      state_q       <= state_d;
      cnt_q         <= cnt_d;
      rd_pend_q     <= mem_re;
      valid_q       <= valid_d;
      first_taken_q <= first_taken_d;
      if (cfg_we_i) begin
        kernel_end_q <= cfg_wdata_i;
      end
      if (commit_fire) begin
        res_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rd_idx_q <= cnt_q[IW-1:0];
    if (in_fire) begin
      mode_q   <= mode_i;
      addr_q   <= address_i;
      amount_q <= amount_i;
      type_q   <= region_type_i;
      hdr_q    <= address_i - bfha_pkg::HDR_BYTES;
      need_q   <= {1'b0, amount_i} + {1'b0, bfha_pkg::HDR_BYTES};
      rend_q   <= {1'b0, address_i} + {1'b0, amount_i};
      fbase_q  <= (address_i > kernel_end_q) ? address_i : kernel_end_q;
    end
    if (state_q == bfha_pkg::ST_SCAN && cnt_q == '0) begin
      blk_end_q <= {1'b0, hdr_q} + {1'b0, amount_q};
      fstart_q  <= {1'b0, fbase_q} + {1'b0, bfha_pkg::FIRST_OFFSET};
    end
    if (commit_fire) begin
      res_addr_q <= res_addr_d;
      res_sts_q  <= res_sts_d;
    end
  end

  bfha_mem #(
    .DEPTH (NUM_HOLES),
    .AW    (IW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (wr_idx),
    .wdata_i (wr_hole),
    .re_i    (mem_re),
    .raddr_i (cnt_q[IW-1:0]),
    .rdata_o (rd_hole)
  );

  bfha_scan #(
    .IW (IW)
  ) u_scan (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .clear_i      (in_fire),
    .vld_i        (rd_pend_q),
    .idx_i        (rd_idx_q),
    .hole_valid_i (valid_q[rd_idx_q]),
    .hole_i       (rd_hole),
    .need_i       (need_q[AW-1:0]),
    .hdr_i        (hdr_q),
    .blk_end_i    (blk_end_q),
    .flags_o      (flags),
    .free_idx_o   (free_idx),
    .best_idx_o   (best_idx),
    .best_hole_o  (best_hole),
    .lo_idx_o     (lo_idx),
    .lo_hole_o    (lo_hole),
    .hi_idx_o     (hi_idx),
    .hi_hole_o    (hi_hole)
  );

  assign add_end     = bfha_pkg::sat33(rend_q);
  assign add_start   = first_taken_q ? addr_q : bfha_pkg::sat33(fstart_q);
  assign new_start   = best_hole.base_addr + need_q[AW-1:0];
  assign blk_sat_end = bfha_pkg::sat33(blk_end_q);

  // commit decision
  always_comb begin
    wr_en         = 1'b0;
    wr_idx        = free_idx;
    wr_hole       = '0;
    set_en        = 1'b0;
    set_idx       = free_idx;
    clr_en        = 1'b0;
    clr_idx       = best_idx;
    first_taken_d = first_taken_q;
    res_addr_d    = '0;
    res_sts_d     = bfha_pkg::STS_OK;
    case (mode_q)
      bfha_pkg::MODE_ADD: begin
        if (type_q == bfha_pkg::TYPE_RAM) begin
          if (!flags.free_found) begin
            res_sts_d = bfha_pkg::STS_FULL;
          end else begin
            first_taken_d = 1'b1;
            if (add_start < add_end) begin
              wr_en   = 1'b1;
              wr_hole = '{base_addr: add_start, end_addr: add_end};
              set_en  = 1'b1;
            end
          end
        end
      end
      bfha_pkg::MODE_ALLOC: begin
        if (amount_q == '0) begin
          res_sts_d = bfha_pkg::STS_ZERO;
        end else if (need_q[AW] || !flags.best_found) begin
          res_sts_d = bfha_pkg::STS_NOMEM;
        end else begin
          res_addr_d = best_hole.base_addr + bfha_pkg::HDR_BYTES;
          wr_en      = 1'b1;
          wr_idx     = best_idx;
          wr_hole    = '{base_addr: new_start, end_addr: best_hole.end_addr};
          clr_en     = (new_start >= best_hole.end_addr);
          clr_idx    = best_idx;
        end
      end
      bfha_pkg::MODE_FREE: begin
        if (addr_q != '0) begin
          if (flags.lo_found && flags.hi_found) begin
            wr_en   = 1'b1;
            wr_idx  = lo_idx;
            wr_hole = '{base_addr: lo_hole.base_addr, end_addr: hi_hole.end_addr};
            clr_en  = 1'b1;
            clr_idx = hi_idx;
          end else if (flags.hi_found) begin
            wr_en   = 1'b1;
            wr_idx  = hi_idx;
            wr_hole = '{base_addr: hdr_q, end_addr: hi_hole.end_addr};
          end else if (flags.lo_found) begin
            wr_en   = 1'b1;
            wr_idx  = lo_idx;
            wr_hole = '{base_addr: lo_hole.base_addr, end_addr: blk_sat_end};
          end else if (amount_q != '0) begin
            if (!flags.free_found) begin
              res_sts_d = bfha_pkg::STS_FULL;
            end else begin
              wr_en   = 1'b1;
              wr_hole = '{base_addr: hdr_q, end_addr: blk_sat_end};
              set_en  = 1'b1;
            end
          end
        end
      end
      default: ;
    endcase
    if (!commit_fire) begin
      wr_en         = 1'b0;
      set_en        = 1'b0;
      clr_en        = 1'b0;
      first_taken_d = first_taken_q;
    end
  end

  always_comb begin
    valid_d = valid_q;
    if (set_en) begin
      valid_d[set_idx] = 1'b1;
    end
    if (clr_en) begin
      valid_d[clr_idx] = 1'b0;
    end
  end

  assign out_valid_o      = res_valid_q;
  assign result_address_o = res_addr_q;
  assign status_o         = res_sts_q;

endmodule

`default_nettype wire

@@ design/bfha_mem.sv @@
`timescale 1ns / 1ps
`default_nettype none

module bfha_mem #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = 4
) (
  input  wire logic           clk_i,
  input  wire logic           we_i,
  input  wire logic [AW-1:0]  waddr_i,
  input  wire bfha_pkg::hole_t wdata_i,
  input  wire logic           re_i,
  input  wire logic [AW-1:0]  raddr_i,
  output bfha_pkg::hole_t     rdata_o
);

  bfha_pkg::hole_t mem_q [DEPTH];
  bfha_pkg::hole_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

@@ design/bfha_scan.sv @@
`timescale 1ns / 1ps
`default_nettype none

module bfha_scan #(
  parameter int unsigned IW = 4
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        clear_i,
  input  wire logic                        vld_i,
  input  wire logic [IW-1:0]               idx_i,
  input  wire logic                        hole_valid_i,
  input  wire bfha_pkg::hole_t             hole_i,
  input  wire logic [bfha_pkg::ADDR_W-1:0] need_i,
  input  wire logic [bfha_pkg::ADDR_W-1:0] hdr_i,
  input  wire logic [bfha_pkg::ADDR_W:0]   blk_end_i,
  output bfha_pkg::scan_flags_t            flags_o,
  output logic [IW-1:0]                    free_idx_o,
  output logic [IW-1:0]                    best_idx_o,
  output bfha_pkg::hole_t                  best_hole_o,
  output logic [IW-1:0]                    lo_idx_o,
  output bfha_pkg::hole_t                  lo_hole_o,
  output logic [IW-1:0]                    hi_idx_o,
  output bfha_pkg::hole_t                  hi_hole_o
);

  bfha_pkg::scan_flags_t flags_q, flags_d;
  logic [IW-1:0] free_idx_q, free_idx_d;
  logic [IW-1:0] best_idx_q, best_idx_d;
  logic [IW-1:0] lo_idx_q, lo_idx_d;
  logic [IW-1:0] hi_idx_q, hi_idx_d;
  bfha_pkg::hole_t best_hole_q, best_hole_d;
  bfha_pkg::hole_t lo_hole_q, lo_hole_d;
  bfha_pkg::hole_t hi_hole_q, hi_hole_d;
  logic [bfha_pkg::ADDR_W-1:0] len;
  logic [bfha_pkg::ADDR_W-1:0] best_len;

  assign len      = hole_i.end_addr - hole_i.base_addr;
  assign best_len = best_hole_q.end_addr - best_hole_q.base_addr;

  always_comb begin
    flags_d     = flags_q;
    free_idx_d  = free_idx_q;
    best_idx_d  = best_idx_q;
    best_hole_d = best_hole_q;
    lo_idx_d    = lo_idx_q;
    lo_hole_d   = lo_hole_q;
    hi_idx_d    = hi_idx_q;
    hi_hole_d   = hi_hole_q;
    if (clear_i) begin
      flags_d = '0;
    end else if (vld_i) begin
      if (!hole_valid_i) begin
        if (!flags_q.free_found) begin
          flags_d.free_found = 1'b1;
          free_idx_d         = idx_i;
        end
      end else begin
        // exact fit wins and freezes the search
        if (!flags_q.best_exact) begin
          if (len == need_i) begin
            flags_d.best_found = 1'b1;
            flags_d.best_exact = 1'b1;
            best_idx_d         = idx_i;
            best_hole_d        = hole_i;
          end else if (len > need_i && (!flags_q.best_found || len < best_len)) begin
            flags_d.best_found = 1'b1;
            best_idx_d         = idx_i;
            best_hole_d        = hole_i;
          end
        end
        if (!flags_q.lo_found && hole_i.end_addr == hdr_i) begin
          flags_d.lo_found = 1'b1;
          lo_idx_d         = idx_i;
          lo_hole_d        = hole_i;
        end
        if (!flags_q.hi_found && {1'b0, hole_i.base_addr} == blk_end_i) begin
          flags_d.hi_found = 1'b1;
          hi_idx_d         = idx_i;
          hi_hole_d        = hole_i;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_q <= '0;
    end else begin
      flags_q <= flags_d;
    end
  end

  always_ff @(posedge clk_i) begin
    free_idx_q  <= free_idx_d;
    best_idx_q  <= best_idx_d;
    best_hole_q <= best_hole_d;
    lo_idx_q    <= lo_idx_d;
    lo_hole_q   <= lo_hole_d;
    hi_idx_q    <= hi_idx_d;
    hi_hole_q   <= hi_hole_d;
  end

  assign flags_o     = flags_q;
  assign free_idx_o  = free_idx_q;
  assign best_idx_o  = best_idx_q;
  assign best_hole_o = best_hole_q;
  assign lo_idx_o    = lo_idx_q;
  assign lo_hole_o   = lo_hole_q;
  assign hi_idx_o    = hi_idx_q;
  assign hi_hole_o   = hi_hole_q;

endmodule

`default_nettype wire

@@ design/bfha_chk.sv @@
`timescale 1ns / 1ps
`default_nettype none

module bfha_chk (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        cfg_we_i,
  input wire logic [31:0] cfg_wdata_i,
  input wire logic        in_valid_i,
  input wire logic        in_ready_o,
  input wire logic [1:0]  mode_i,
  input wire logic [31:0] address_i,
  input wire logic [31:0] amount_i,
  input wire logic [7:0]  region_type_i,
  input wire logic        out_valid_o,
  input wire logic        out_ready_i,
  input wire logic [31:0] result_address_o,
  input wire logic [1:0]  status_o
);

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(result_address_o)
      && $stable(status_o))
    else $error("stalled result changed");

  // only a successful allocation carries a pointer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != bfha_pkg::STS_OK |-> result_address_o == '0)
    else $error("pointer with error status");

  // accepting an item makes the block busy
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("item accepted while busy");

  // a new result appears only after a busy cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o))
    else $error("result without work");

endmodule

bind best_fit_hole_allocator bfha_chk u_bfha_chk (.*);

`default_nettype wire

@@ tb/sv/hole_table_checker.sv @@
`timescale 1ns / 1ps

module hole_table_checker #(
  parameter int unsigned NUM_HOLES = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [31:0] cfg_wdata_i,
  input  wire logic        in_valid_i,
  input  wire logic        in_ready_i,
  input  wire logic [1:0]  mode_i,
  input  wire logic [31:0] address_i,
  input  wire logic [31:0] amount_i,
  input  wire logic [7:0]  region_type_i,
  input  wire logic        out_valid_i,
  input  wire logic        out_ready_i,
  input  wire logic [31:0] result_address_i,
  input  wire logic [1:0]  status_i,
  output int unsigned      fail_count_o,
  output int unsigned      outstanding_o
);

  typedef struct {
    logic [31:0] ptr;
    logic [1:0]  status;
  } alloc_reply_t;

  logic [31:0]  gap_lo [NUM_HOLES];
  logic [31:0]  gap_hi [NUM_HOLES];
  logic         gap_live [NUM_HOLES];
  logic         first_seen;
  logic [31:0]  kernel_end_q;
  alloc_reply_t predicted_replies [$];

  function automatic logic [31:0] clamp_add(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    return sum[32] ? bfha_pkg::ADDR_MAX : sum[31:0];
  endfunction

  function automatic int open_slot();
    int i;
    for (i = 0; i < NUM_HOLES; i++) begin
      if (!gap_live[i]) return i;
    end
    return -1;
  endfunction

  function automatic logic [1:0] add_region(input logic [31:0] base_addr,
                                            input logic [31:0] len,
                                            input logic [7:0]  kind);
    logic [31:0] lo_addr;
    logic [31:0] hi_addr;
    int slot;
    if (kind != bfha_pkg::TYPE_RAM) return bfha_pkg::STS_OK;
    slot = open_slot();
    if (slot < 0) return bfha_pkg::STS_FULL;
    hi_addr = clamp_add(base_addr, len);
    if (!first_seen) begin
      lo_addr = clamp_add((base_addr > kernel_end_q) ? base_addr : kernel_end_q,
                          bfha_pkg::FIRST_OFFSET);
      first_seen = 1'b1;
    end else begin
      lo_addr = base_addr;
    end
    if (lo_addr < hi_addr) begin
      gap_lo[slot]   = lo_addr;
      gap_hi[slot]   = hi_addr;
      gap_live[slot] = 1'b1;
    end
    return bfha_pkg::STS_OK;
  endfunction

  function automatic logic [1:0] carve(input logic [31:0] req, output logic [31:0] ptr);
    logic [31:0] need;
    logic [31:0] span;
    logic [31:0] best_span;
    int best;
    int i;
    ptr = '0;
    best = -1;
    best_span = '0;
    if (req == '0) return bfha_pkg::STS_ZERO;
    if (req > bfha_pkg::ADDR_MAX - bfha_pkg::HDR_BYTES) return bfha_pkg::STS_NOMEM;
    need = req + bfha_pkg::HDR_BYTES;
    for (i = 0; i < NUM_HOLES; i++) begin
      if (gap_live[i]) begin
        span = gap_hi[i] - gap_lo[i];
        if (span == need) begin
          best = i;
          break;
        end
        if (span > need && (best < 0 || span < best_span)) begin
          best = i;
          best_span = span;
        end
      end
    end
    if (best < 0) return bfha_pkg::STS_NOMEM;
    ptr = gap_lo[best] + bfha_pkg::HDR_BYTES;
    gap_lo[best] = gap_lo[best] + need;
    if (gap_lo[best] >= gap_hi[best]) gap_live[best] = 1'b0;
    return bfha_pkg::STS_OK;
  endfunction

  function automatic logic [1:0] give_back(input logic [31:0] ptr, input logic [31:0] span);
    logic [31:0] hdr;
    logic [32:0] tail;
    int lo;
    int hi;
    int slot;
    int i;
    lo = -1;
    hi = -1;
    if (ptr == '0) return bfha_pkg::STS_OK;
    hdr  = ptr - bfha_pkg::HDR_BYTES;
    tail = {1'b0, hdr} + {1'b0, span};
    for (i = 0; i < NUM_HOLES; i++) begin
      if (gap_live[i]) begin
        if (lo < 0 && gap_hi[i] == hdr) lo = i;
        if (hi < 0 && {1'b0, gap_lo[i]} == tail) hi = i;
      end
    end
    if (lo >= 0 && hi >= 0) begin
      gap_hi[lo]   = gap_hi[hi];
      gap_live[hi] = 1'b0;
    end else if (hi >= 0) begin
      gap_lo[hi] = hdr;
    end else if (lo >= 0) begin
      gap_hi[lo] = clamp_add(hdr, span);
    end else begin
      if (span == '0) return bfha_pkg::STS_OK;
      slot = open_slot();
      if (slot < 0) return bfha_pkg::STS_FULL;
      gap_lo[slot]   = hdr;
      gap_hi[slot]   = clamp_add(hdr, span);
      gap_live[slot] = 1'b1;
    end
    return bfha_pkg::STS_OK;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    alloc_reply_t reply;
    alloc_reply_t want;
    logic [31:0]  ptr;
    int           i;
    if (!rst_ni) begin
      for (i = 0; i < NUM_HOLES; i++) begin
        gap_lo[i]   = '0;
        gap_hi[i]   = '0;
        gap_live[i] = 1'b0;
      end
      first_seen   = 1'b0;
      kernel_end_q = '0;
      predicted_replies.delete();
    end else begin
      if (cfg_we_i) kernel_end_q = cfg_wdata_i;
      if (in_valid_i && in_ready_i) begin
        ptr = '0;
        case (mode_i)
          bfha_pkg::MODE_ADD: begin
            reply.status = add_region(address_i, amount_i, region_type_i);
          end
          bfha_pkg::MODE_ALLOC: begin
            reply.status = carve(amount_i, ptr);
          end
          bfha_pkg::MODE_FREE: begin
            reply.status = give_back(address_i, amount_i);
          end
          default: begin
            reply.status = bfha_pkg::STS_OK;
          end
        endcase
        reply.ptr = ptr;
        predicted_replies.push_back(reply);
      end
      if (out_valid_i && out_ready_i) begin
        if (predicted_replies.size() == 0) begin
          $error("result with no item outstanding: result_address %h status %0d",
                 result_address_i, status_i);
          fail_count_o = fail_count_o + 1;
        end else begin
          want = predicted_replies.pop_front();
          if (result_address_i !== want.ptr) begin
            $error("result_address: expected %h, actual %h", want.ptr, result_address_i);
            fail_count_o = fail_count_o + 1;
          end
          if (status_i !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, status_i);
            fail_count_o = fail_count_o + 1;
          end
        end
      end
    end
    outstanding_o = predicted_replies.size();
  end

endmodule

@@ tb/sv/tb.sv @@
`timescale 1ns / 1ps

module tb;

  localparam int unsigned HOLES       = 16;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned PHASE_ITEMS = 600;
  localparam logic [1:0]  MODE_NONE   = 2'd3;

  typedef struct {
    logic [1:0]  mode;
    logic [31:0] amount;
  } request_t;

  typedef struct {
    logic [31:0] ptr;
    logic [31:0] span;
  } block_t;

  logic        clk          = 1'b0;
  logic        rst_n        = 1'b0;
  logic        cfg_we       = 1'b0;
  logic [31:0] cfg_wdata    = '0;
  logic        in_valid     = 1'b0;
  logic        in_ready;
  logic [1:0]  mode         = bfha_pkg::MODE_ADD;
  logic [31:0] address      = '0;
  logic [31:0] amount       = '0;
  logic [7:0]  region_type  = '0;
  logic        out_valid;
  logic        out_ready    = 1'b0;
  logic [31:0] result_address;
  logic [1:0]  status;
  logic        steady       = 1'b0;
  int unsigned cycles       = 0;
  int unsigned fail_count;
  int unsigned outstanding;

  request_t sent_requests [$];
  block_t   live_blocks [$];

  best_fit_hole_allocator #(
    .NUM_HOLES(HOLES)
  ) dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_wdata_i     (cfg_wdata),
    .in_valid_i      (in_valid),
    .in_ready_o      (in_ready),
    .mode_i          (mode),
    .address_i       (address),
    .amount_i        (amount),
    .region_type_i   (region_type),
    .out_valid_o     (out_valid),
    .out_ready_i     (out_ready),
    .result_address_o(result_address),
    .status_o        (status)
  );

  hole_table_checker #(
    .NUM_HOLES(HOLES)
  ) reply_check (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_wdata_i     (cfg_wdata),
    .in_valid_i      (in_valid),
    .in_ready_i      (in_ready),
    .mode_i          (mode),
    .address_i       (address),
    .amount_i        (amount),
    .region_type_i   (region_type),
    .out_valid_i     (out_valid),
    .out_ready_i     (out_ready),
    .result_address_i(result_address),
    .status_i        (status),
    .fail_count_o    (fail_count),
    .outstanding_o   (outstanding)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $error("cycle limit reached with %0d results outstanding", outstanding);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  always @(negedge clk) begin
    out_ready <= steady || ($urandom_range(0, 99) >= 25);
  end

  // remember granted blocks so that later frees hand back real pointers
  always @(posedge clk) begin : track_blocks
    request_t req;
    block_t   blk;
    if (in_valid && in_ready) begin
      req.mode   = mode;
      req.amount = amount;
      sent_requests.push_back(req);
    end
    if (out_valid && out_ready && sent_requests.size() != 0) begin
      req = sent_requests.pop_front();
      if (req.mode == bfha_pkg::MODE_ALLOC && status == bfha_pkg::STS_OK
          && result_address != '0) begin
        blk.ptr  = result_address;
        blk.span = req.amount + bfha_pkg::HDR_BYTES;
        live_blocks.push_back(blk);
      end
    end
  end

  task automatic send_item(input logic [1:0] m, input logic [31:0] a,
                           input logic [31:0] n, input logic [7:0] t);
    @(negedge clk);
    while (!steady && $urandom_range(0, 99) < 25) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid    <= 1'b1;
    mode        <= m;
    address     <= a;
    amount      <= n;
    region_type <= t;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
  endtask

  task automatic write_kernel_end(input logic [31:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic random_item();
    int unsigned pick;
    int unsigned idx;
    block_t      blk;
    logic [31:0] size;
    pick = $urandom_range(0, 99);
    if (pick >= 52 && pick < 88 && live_blocks.size() == 0) pick = 30;
    if (pick < 12) begin
      send_item(bfha_pkg::MODE_ADD, 32'h0100_0000 + (32'($urandom_range(0, 255)) << 12),
                32'($urandom_range(1, 64)) << 6,
                ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                            : bfha_pkg::TYPE_RAM);
    end else if (pick < 52) begin
      size = ($urandom_range(0, 9) == 0) ? 32'($urandom_range(1, 32'h2000))
                                         : 32'($urandom_range(1, 256));
      send_item(bfha_pkg::MODE_ALLOC, $urandom, size, 8'($urandom_range(0, 255)));
    end else if (pick < 88) begin
      idx = $urandom_range(0, live_blocks.size() - 1);
      blk = live_blocks[idx];
      live_blocks.delete(idx);
      size = blk.span;
      // a wrong size now and then
      if ($urandom_range(0, 9) == 0) begin
        size = $urandom_range(0, 1) ? size + bfha_pkg::HDR_BYTES
                                    : size - bfha_pkg::HDR_BYTES;
      end
      send_item(bfha_pkg::MODE_FREE, blk.ptr, size, 8'($urandom_range(0, 255)));
    end else begin
      send_item(2'($urandom_range(0, 3)), $urandom, $urandom, 8'($urandom_range(0, 255)));
    end
  endtask

  initial begin : stimulus
    int unsigned i;
    int unsigned k;
    int unsigned p;
    logic [31:0] first_kernel_end;
    wait (rst_n === 1'b1);

    case ($urandom_range(0, 2))
      0: first_kernel_end = '0;
      1: first_kernel_end = 32'($urandom_range(32'h0040_0000, 32'h0080_0000));
      default: first_kernel_end = bfha_pkg::ADDR_MAX;
    endcase
    write_kernel_end(bfha_pkg::ADDR_MAX);
    write_kernel_end(first_kernel_end);

    // region handling, then allocate corner cases
    send_item(bfha_pkg::MODE_ADD, 32'h0000_1000, 32'h0000_1000, 8'd2);
    send_item(bfha_pkg::MODE_ADD, 32'h0000_1000, 32'h0200_0000, bfha_pkg::TYPE_RAM);
    send_item(bfha_pkg::MODE_ADD, 32'h0400_0000, 32'h0000_1000, bfha_pkg::TYPE_RAM);
    send_item(bfha_pkg::MODE_ADD, 32'hFFFF_0000, 32'h0002_0000, bfha_pkg::TYPE_RAM);
    send_item(bfha_pkg::MODE_ADD, 32'h0500_0000, 32'h0000_0000, bfha_pkg::TYPE_RAM);
    send_item(bfha_pkg::MODE_ALLOC, bfha_pkg::ADDR_MAX, 32'h0000_0000, 8'hFF);
    send_item(bfha_pkg::MODE_ALLOC, 32'h0, 32'hFFFF_FFFC, 8'h00);
    send_item(bfha_pkg::MODE_ALLOC, 32'h0, 32'hFFFF_FFFB, 8'h00);
    send_item(bfha_pkg::MODE_ALLOC, 32'h0, 32'h0000_0FFC, 8'h00);
    send_item(bfha_pkg::MODE_ALLOC, 32'h0, 32'h0000_007C, 8'h00);

    // isolated free, merge below, merge above, merge on both sides
    send_item(bfha_pkg::MODE_FREE, 32'h0400_0004, 32'h0000_1000, 8'h00);
    send_item(bfha_pkg::MODE_FREE, 32'h0400_1004, 32'h0000_0040, 8'h00);
    send_item(bfha_pkg::MODE_FREE, 32'h03FF_FFC4, 32'h0000_0040, 8'h00);
    send_item(bfha_pkg::MODE_ADD, 32'h0400_2000, 32'h0000_1000, bfha_pkg::TYPE_RAM);
    send_item(bfha_pkg::MODE_FREE, 32'h0400_1044, 32'h0000_0FC0, 8'h00);

    // wrapping header, saturating ends, null and empty blocks, unused mode
    send_item(bfha_pkg::MODE_FREE, 32'h0000_0003, 32'h0000_0010, 8'h00);
    send_item(bfha_pkg::MODE_FREE, 32'h0000_0002, 32'h0000_0010, 8'h00);
    send_item(bfha_pkg::MODE_FREE, 32'h0000_0000, 32'h0000_0100, 8'h00);
    send_item(bfha_pkg::MODE_FREE, 32'h0600_0000, 32'h0000_0000, 8'h00);
    send_item(MODE_NONE, bfha_pkg::ADDR_MAX, bfha_pkg::ADDR_MAX, 8'hFF);

    // fill the table, then overflow it from both sides
    for (i = 0; i < 14; i++) begin
      send_item(bfha_pkg::MODE_ADD, 32'h0800_0000 + (i << 12), 32'h0000_0100,
                bfha_pkg::TYPE_RAM);
    end
    send_item(bfha_pkg::MODE_FREE, 32'h0900_0004, 32'h0000_0040, 8'h00);
    drain();

    for (p = 0; p < 3; p++) begin
      case (p)
        0: write_kernel_end('0);
        1: write_kernel_end(bfha_pkg::ADDR_MAX);
        default: write_kernel_end($urandom);
      endcase
      for (k = 0; k < PHASE_ITEMS; k++) begin
        steady = (p == 1 && k < PHASE_ITEMS / 2);
        if (p == 0 && k == PHASE_ITEMS / 2) drain();
        random_item();
      end
      steady = 1'b0;
      drain();
    end

    repeat (40) @(posedge clk);
    if (fail_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
